// ----- sv/ihp_pkg.sv -----
// Shared constants and codes of the indexed max-heap.
package ihp_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SLOT_W         = 8;
  localparam int POS_W          = 9;
  localparam logic [POS_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OCCUPIED = 3'd4
  } status_t;

endpackage

// ----- sv/ihp_if.sv -----
// Request and result channel interfaces of the indexed max-heap.
interface ihp_req_if #(parameter int VALUE_BITS = ihp_pkg::VALUE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [ihp_pkg::SLOT_W-1:0]    slot;
  logic signed [VALUE_BITS-1:0]  value;

  modport source (output valid, operation, slot, value, input ready);
  modport sink   (input valid, operation, slot, value, output ready);
endinterface

interface ihp_rsp_if #(parameter int VALUE_BITS = ihp_pkg::VALUE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic [ihp_pkg::SLOT_W-1:0]    result_slot;
  logic signed [VALUE_BITS-1:0]  result_value;
  logic [ihp_pkg::POS_W-1:0]     entry_count;
  logic                          is_empty;
  logic [2:0]                    status;

  modport source (output valid, result_slot, result_value, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, result_slot, result_value, entry_count, is_empty, status,
                  output ready);
endinterface

// ----- sv/ihp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/index_max_heap.sv -----
// Top level of the indexed max-heap: sequencer, slot store and heap order store.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        operation, slot, value
//  out_ch    out  valid/ready        result_slot, result_value, entry_count, is_empty, status
//  cfg       in   cfg_we             cfg_data = entry_limit
//
// One item at a time. Read and errors pass the sequencer's accept, decode and hand-off
// states; insert adds a sift-up (check, order read, slot read, swap per level), extract
// and change add a sift-down (check, left reads, right read, decide per level, no right
// read with no right child), change after a sift-up that left the entry in place.
// The sift loop is paced by registered reads of the order store, then the slot store.
// Reset is synchronous; slot valid bits clear at once, no clearing pass.
// A waiting result does not block acceptance; it holds the sequencer only at hand-off.
module index_max_heap #(
  parameter int CAPACITY   = ihp_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ihp_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  ihp_req_if.sink                    in_ch,
  ihp_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ihp_pkg::POS_W-1:0]  cfg_data
);
  import ihp_pkg::*;

  localparam int SLOTS   = (CAPACITY > 256) ? 256 : CAPACITY;
  localparam int AW      = $clog2(SLOTS);
  localparam int CAP_CLP = (CAPACITY > 511) ? 511 : CAPACITY;
  localparam logic [POS_W-1:0] CAP9 = POS_W'(CAP_CLP);
  localparam int SW      = VALUE_BITS + POS_W;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DEC     = 15'b000000000000010,
    S_EXT_TOP = 15'b000000000000100,
    S_EXT_LO  = 15'b000000000001000,
    S_EXT_LS  = 15'b000000000010000,
    S_UP_CHK  = 15'b000000000100000,
    S_UP_O    = 15'b000000001000000,
    S_UP_S    = 15'b000000010000000,
    S_DN_CHK  = 15'b000000100000000,
    S_DN_OL   = 15'b000001000000000,
    S_DN_SL   = 15'b000010000000000,
    S_DN_SR   = 15'b000100000000000,
    S_DN_DEC  = 15'b001000000000000,
    S_PLACE   = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_t;

  state_t state;

  // control
  logic [POS_W-1:0] limit, count;
  logic             moved;
  logic             out_valid;

  // payload
  op_t                     op;
  logic [SLOT_W-1:0]       in_slot, rslot, mv_slot, l_slot, r_slot, c_slot;
  logic signed [VALUE_BITS-1:0] in_val, rval, mv_val, l_val, c_val;
  logic [POS_W-1:0]        k, c_pos;
  status_t                 status;

  // memory ports
  logic          s_we, s_re, o_we, o_re;
  logic [AW-1:0] s_waddr, s_raddr, o_waddr, o_raddr;
  logic [SW-1:0] s_wdata, s_q;
  logic [SLOT_W-1:0] o_wdata, o_q;
  logic [SLOTS-1:0]  slot_vld;
  logic              s_vld_q;

  logic signed [VALUE_BITS-1:0] s_val;
  logic [POS_W-1:0]  s_pos;
  logic [POS_W-1:0]  lim;
  logic [POS_W:0]    c_left;
  logic              in_fire, has_left, has_right, slot_bad;

  function automatic logic [AW-1:0] pa(input logic [POS_W:0] p);
    logic [POS_W:0] t;
    t = p - (POS_W+1)'(1);
    return t[AW-1:0];
  endfunction

  assign lim       = (limit > CAP9) ? CAP9 : limit;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign s_val     = s_vld_q ? s_q[SW-1:POS_W] : '0;
  assign s_pos     = s_vld_q ? s_q[POS_W-1:0] : '0;
  assign c_left    = {k, 1'b0};
  assign has_left  = (c_left <= {1'b0, count});
  assign has_right = ((c_left + (POS_W+1)'(1)) <= {1'b0, count});
  assign slot_bad  = ({1'b0, in_slot} >= lim);

  ihp_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_q)
  );

  ihp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .re(o_re), .raddr(o_raddr), .rdata(o_q)
  );

  // memory port steering
  always_comb begin
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_re = 1'b0; o_raddr = '0;
    unique case (state)
      S_IDLE: begin
        s_re = in_fire; s_raddr = in_ch.slot[AW-1:0];
        o_re = in_fire; o_raddr = '0;
      end
      S_DEC: begin
        if (op == OP_EXTRACT && count != '0) begin
          s_re = 1'b1; s_raddr = o_q[AW-1:0];
        end
        if (op == OP_CHANGE && !slot_bad && s_pos == '0) begin
          s_we = 1'b1; s_waddr = in_slot[AW-1:0]; s_wdata = {in_val, POS_W'(0)};
        end
      end
      S_EXT_TOP: begin
        s_we = 1'b1; s_waddr = rslot[AW-1:0]; s_wdata = {s_val, POS_W'(0)};
        o_re = (count != POS_W'(1)); o_raddr = pa({1'b0, count});
      end
      S_EXT_LO, S_UP_O: begin
        s_re = 1'b1; s_raddr = o_q[AW-1:0];
      end
      S_UP_CHK: begin
        o_re = (k > POS_W'(1)); o_raddr = pa({2'b0, k[POS_W-1:1]});
      end
      S_UP_S: begin
        if (s_val < mv_val) begin
          o_we = 1'b1; o_waddr = pa({1'b0, k}); o_wdata = o_q;
          s_we = 1'b1; s_waddr = o_q[AW-1:0]; s_wdata = {s_val, k};
        end
      end
      S_DN_CHK: begin
        o_re = has_left; o_raddr = pa(c_left);
      end
      S_DN_OL: begin
        s_re = 1'b1; s_raddr = o_q[AW-1:0];
        o_re = has_right; o_raddr = c_left[AW-1:0];
      end
      S_DN_SL: begin
        s_re = has_right; s_raddr = o_q[AW-1:0];
      end
      S_DN_DEC: begin
        if (mv_val < c_val) begin
          o_we = 1'b1; o_waddr = pa({1'b0, k}); o_wdata = c_slot;
          s_we = 1'b1; s_waddr = c_slot[AW-1:0]; s_wdata = {c_val, k};
        end
      end
      S_PLACE: begin
        o_we = 1'b1; o_waddr = pa({1'b0, k}); o_wdata = mv_slot;
        s_we = 1'b1; s_waddr = mv_slot[AW-1:0]; s_wdata = {mv_val, k};
      end
      default: begin
      end
    endcase
  end

  // slot valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (s_we) begin
      slot_vld[s_waddr] <= 1'b1;
    end
    if (s_re) begin
      s_vld_q <= slot_vld[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      moved     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op      <= op_t'(in_ch.operation);
            in_slot <= in_ch.slot;
            in_val  <= in_ch.value;
            moved   <= 1'b0;
            state   <= S_DEC;
          end
        end
        S_DEC: begin
          status <= ST_OK;
          rslot  <= in_slot;
          rval   <= '0;
          state  <= S_FIN;
          unique case (op)
            OP_INSERT: begin
              if (count >= lim) begin
                status <= ST_FULL;
              end else if (slot_bad) begin
                status <= ST_RANGE;
              end else if (s_pos != '0) begin
                status <= ST_OCCUPIED;
              end else begin
                count   <= count + POS_W'(1);
                k       <= count + POS_W'(1);
                mv_slot <= in_slot;
                mv_val  <= in_val;
                state   <= S_UP_CHK;
              end
            end
            OP_EXTRACT: begin
              if (count == '0) begin
                status <= ST_EMPTY;
              end else begin
                rslot <= o_q;
                state <= S_EXT_TOP;
              end
            end
            OP_CHANGE: begin
              if (slot_bad) begin
                status <= ST_RANGE;
              end else if (s_pos != '0) begin
                k       <= s_pos;
                mv_slot <= in_slot;
                mv_val  <= in_val;
                state   <= S_UP_CHK;
              end
            end
            OP_READ: begin
              if (slot_bad) begin
                status <= ST_RANGE;
              end else begin
                rval <= s_val;
              end
            end
            default: begin
            end
          endcase
        end
        S_EXT_TOP: begin
          rval <= s_val;
          if (count == POS_W'(1)) begin
            count <= '0;
            state <= S_FIN;
          end else begin
            state <= S_EXT_LO;
          end
        end
        S_EXT_LO: state <= S_EXT_LS;
        S_EXT_LS: begin
          mv_slot <= o_q;
          mv_val  <= s_val;
          count   <= count - POS_W'(1);
          k       <= POS_W'(1);
          state   <= S_DN_CHK;
        end
        S_UP_CHK: begin
          if (k > POS_W'(1)) begin
            state <= S_UP_O;
          end else begin
            state <= (op == OP_CHANGE && !moved) ? S_DN_CHK : S_PLACE;
          end
        end
        S_UP_O: state <= S_UP_S;
        S_UP_S: begin
          if (s_val < mv_val) begin
            k     <= {1'b0, k[POS_W-1:1]};
            moved <= 1'b1;
            state <= S_UP_CHK;
          end else begin
            state <= (op == OP_CHANGE && !moved) ? S_DN_CHK : S_PLACE;
          end
        end
        S_DN_CHK: state <= has_left ? S_DN_OL : S_PLACE;
        S_DN_OL: begin
          l_slot <= o_q;
          state  <= S_DN_SL;
        end
        S_DN_SL: begin
          l_val <= s_val;
          if (has_right) begin
            r_slot <= o_q;
            state  <= S_DN_SR;
          end else begin
            c_slot <= l_slot;
            c_val  <= s_val;
            c_pos  <= c_left[POS_W-1:0];
            state  <= S_DN_DEC;
          end
        end
        S_DN_SR: begin
          // right child wins only when strictly larger
          if (l_val < s_val) begin
            c_slot <= r_slot;
            c_val  <= s_val;
            c_pos  <= c_left[POS_W-1:0] + POS_W'(1);
          end else begin
            c_slot <= l_slot;
            c_val  <= l_val;
            c_pos  <= c_left[POS_W-1:0];
          end
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (mv_val < c_val) begin
            k     <= c_pos;
            state <= S_DN_CHK;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded on hand-off
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ch.ready)) begin
      out_ch.result_slot  <= rslot;
      out_ch.result_value <= rval;
      out_ch.entry_count  <= count;
      out_ch.is_empty     <= (count == '0);
      out_ch.status       <= status;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ----- sv/ihp_check.sv -----
// Port-level checker for the indexed max-heap, bound to the top level.
module ihp_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ihp_pkg::POS_W-1:0] entry_count,
  input logic                      is_empty,
  input logic [2:0]                status
);
  import ihp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> is_empty)
    else $error("empty error with entries present");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind index_max_heap ihp_check u_ihp_check (
  .clk(clk),
  .rst(rst),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .entry_count(out_ch.entry_count),
  .is_empty(out_ch.is_empty),
  .status(out_ch.status)
);
